// ===== rtl/core/gop_reverse_frame_buffer_core_defines.svh =====
// Assertion macros shared by the reverse frame buffer core.
`ifndef GOP_REVERSE_FRAME_BUFFER_CORE_DEFINES_SVH
`define GOP_REVERSE_FRAME_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GRFB_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GRFB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/grfb_pkg.sv =====
// Shared widths, request and result codes, and control structs of the frame buffer core.
package grfb_pkg;

  localparam int REQ_W    = 2;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] RS_PUSHED     = 3'd0;
  localparam logic [STATUS_W-1:0] RS_NO_GROUP   = 3'd1;
  localparam logic [STATUS_W-1:0] RS_OVERFLOW   = 3'd2;
  localparam logic [STATUS_W-1:0] RS_READY      = 3'd3;
  localparam logic [STATUS_W-1:0] RS_NOT_READY  = 3'd4;
  localparam logic [STATUS_W-1:0] RS_RELEASED   = 3'd5;
  localparam logic [STATUS_W-1:0] RS_POPPED     = 3'd6;
  localparam logic [STATUS_W-1:0] RS_NOT_POPPED = 3'd7;

  typedef struct packed {
    logic load;
    logic decide;
    logic finish;
  } grfb_cmd_t;

  typedef struct packed {
    logic out_free;
  } grfb_stat_t;

endpackage

// ===== rtl/core/grfb_req_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
interface grfb_req_if;
  import grfb_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [HANDLE_W-1:0] frame_handle;
  logic                is_key_frame;

  modport source (output valid, output req_type, output frame_handle, output is_key_frame,
                  input ready);
  modport sink (input valid, input req_type, input frame_handle, input is_key_frame,
                output ready);
endinterface

// ===== rtl/core/grfb_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result word.
interface grfb_rsp_if;
  import grfb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;

  modport source (output valid, output status, output out_handle, input ready);
  modport sink (input valid, input status, input out_handle, output ready);
endinterface

// ===== rtl/core/grfb_store.sv =====
// Single-port-write, single-port-read frame handle memory with registered read data.
module grfb_store #(
  parameter int DEPTH = 256,
  parameter int DW    = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/grfb_ctrl.sv =====
// Sequencing state machine: accept, decide, and deliver steps for each request word.
module grfb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  grfb_pkg::grfb_stat_t   stat,
  output grfb_pkg::grfb_cmd_t    cmd
);
  import grfb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // A new word may enter in the same cycle the previous result is registered.
  assign req_ready  = (state == S_IDLE) || ((state == S_FINISH) && stat.out_free);
  assign cmd.load   = req_valid && req_ready;
  assign cmd.decide = (state == S_DECIDE);
  assign cmd.finish = (state == S_FINISH) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = cmd.load ? S_DECIDE : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/grfb_dp.sv =====
// Datapath: group state, display queue, frame store and the output register.
`include "gop_reverse_frame_buffer_core_defines.svh"

module grfb_dp #(
  parameter int GROUPS           = 4,
  parameter int FRAMES_PER_GROUP = 64,
  parameter int HANDLE_BITS      = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  grfb_pkg::grfb_cmd_t                 cmd,
  output grfb_pkg::grfb_stat_t                stat,
  input  logic [grfb_pkg::REQ_W-1:0]          req_type,
  input  logic [grfb_pkg::HANDLE_W-1:0]       frame_handle,
  input  logic                                is_key_frame,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [grfb_pkg::STATUS_W-1:0]       status,
  output logic [grfb_pkg::HANDLE_W-1:0]       out_handle
);
  import grfb_pkg::*;

  localparam int GW = $clog2(GROUPS);
  localparam int CW = $clog2(GROUPS + 1);
  localparam int TW = GW + 1;
  localparam int FW = $clog2(FRAMES_PER_GROUP + 1);
  localparam int SW = $clog2(FRAMES_PER_GROUP);
  localparam int AW = $clog2(GROUPS * FRAMES_PER_GROUP);
  localparam int DW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  // Latched request word.
  logic [REQ_W-1:0]    req_q;
  logic [DW-1:0]       handle_q;
  logic                key_q;

  // Per-group state: busy means closed and not yet released, or processing.
  logic [GROUPS-1:0]   busy;
  logic [GROUPS-1:0]   proc;
  logic [GROUPS-1:0]   nonempty;
  logic [GROUPS-1:0]   queued;
  logic [FW-1:0]       fill [GROUPS];

  logic [GW-1:0]       write_group;
  logic [GW-1:0]       fifo [GROUPS];
  logic [GW-1:0]       fifo_head;
  logic [CW-1:0]       fifo_count;
  logic [STATUS_W-1:0] result_q;

  logic [GW-1:0]       g;
  logic [GW-1:0]       nx;
  logic [GW-1:0]       hg;
  logic [GW-1:0]       tgt;
  logic [GW-1:0]       sel;
  logic [GW-1:0]       tail;
  logic [GW-1:0]       head_next;
  logic [TW-1:0]       tail_sum;
  logic [FW-1:0]       sel_fill;
  logic [FW-1:0]       sel_fill_dec;
  logic [SW-1:0]       slot;
  logic [AW-1:0]       addr;
  logic [STATUS_W-1:0] result;
  logic [DW-1:0]       rdata;
  logic                is_push;
  logic                is_peek;
  logic                is_pop;
  logic                q_empty;
  logic                close;
  logic                g_free;
  logic                no_group;
  logic                full_stack;
  logic                enqueue;
  logic                do_store;
  logic                rel_group;
  logic                peek_hit;
  logic                do_pop;
  logic                we;
  logic                re;

  always_comb begin
    is_push  = (req_q == REQ_PUSH);
    is_peek  = (req_q == REQ_PEEK);
    is_pop   = (req_q == REQ_POP);
    q_empty  = (fifo_count == '0);

    g  = write_group;
    nx = (g == GW'(GROUPS - 1)) ? '0 : g + GW'(1);
    hg = fifo[fifo_head];

    // A key frame on a non-empty stack closes the current group.
    close    = key_q && nonempty[g];
    g_free   = !close && !busy[g];
    tgt      = g_free ? g : nx;
    no_group = !g_free && busy[nx];

    sel          = is_push ? tgt : hg;
    sel_fill     = fill[sel];
    sel_fill_dec = sel_fill - FW'(1);
    full_stack   = (sel_fill == FW'(FRAMES_PER_GROUP));

    enqueue  = is_push && close && !queued[g] && (fifo_count != CW'(GROUPS));
    tail_sum = TW'(fifo_head) + TW'(fifo_count);
    tail     = (tail_sum >= TW'(GROUPS)) ? GW'(tail_sum - TW'(GROUPS)) : GW'(tail_sum);
    head_next = (fifo_head == GW'(GROUPS - 1)) ? '0 : fifo_head + GW'(1);

    do_store  = is_push && !no_group && !full_stack;
    rel_group = is_peek && !q_empty && !nonempty[hg];
    peek_hit  = is_peek && !q_empty && nonempty[hg] && busy[hg];
    do_pop    = is_pop && !q_empty && nonempty[hg];

    // Pushes write at the fill level; peeks read the entry just below it.
    slot = is_push ? sel_fill[SW-1:0] : sel_fill_dec[SW-1:0];
    addr = AW'(sel) * AW'(FRAMES_PER_GROUP) + AW'(slot);
    we   = cmd.decide && do_store;
    re   = cmd.decide && peek_hit;

    unique case (req_q)
      REQ_PUSH: result = no_group ? RS_NO_GROUP : (full_stack ? RS_OVERFLOW : RS_PUSHED);
      REQ_PEEK: result = rel_group ? RS_RELEASED : (peek_hit ? RS_READY : RS_NOT_READY);
      REQ_POP:  result = do_pop ? RS_POPPED : RS_NOT_POPPED;
      default:  result = RS_NOT_READY;
    endcase
  end

  grfb_store #(
    .DEPTH (GROUPS * FRAMES_PER_GROUP),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (handle_q),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= '0;
      proc        <= '0;
      nonempty    <= '0;
      queued      <= '0;
      write_group <= '0;
      fifo_head   <= '0;
      fifo_count  <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (cmd.decide) begin
        if (is_push) begin
          if (close) begin
            busy[g] <= 1'b1;
            proc[g] <= 1'b0;
          end
          if (enqueue) begin
            queued[g]  <= 1'b1;
            fifo_count <= fifo_count + CW'(1);
          end
          if (!g_free && !no_group) begin
            write_group <= nx;
          end
          if (do_store) begin
            fill[tgt]     <= sel_fill + FW'(1);
            nonempty[tgt] <= 1'b1;
          end
        end
        if (rel_group) begin
          fifo_head  <= head_next;
          fifo_count <= fifo_count - CW'(1);
          queued[hg] <= 1'b0;
          busy[hg]   <= 1'b0;
          proc[hg]   <= 1'b0;
        end
        if (peek_hit) begin
          proc[hg] <= 1'b1;
        end
        if (do_pop) begin
          fill[hg]     <= sel_fill_dec;
          nonempty[hg] <= (sel_fill_dec != '0);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= req_type;
      handle_q <= frame_handle[DW-1:0];
      key_q    <= is_key_frame;
    end
    if (cmd.decide) begin
      result_q <= result;
      if (enqueue) begin
        fifo[tail] <= g;
      end
    end
    if (cmd.finish) begin
      status     <= result_q;
      out_handle <= (result_q == RS_READY) ? HANDLE_W'(rdata) : '0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  `GRFB_ASSERT_IMPLY(a_queue_count, clk, rst, 1'b1, $countones(queued) == int'(fifo_count), "display queue count disagrees with queued flags")
  `GRFB_ASSERT_IMPLY(a_queued_busy, clk, rst, 1'b1, (queued & ~busy) == '0, "queued group is free for insert")
  `GRFB_ASSERT_IMPLY(a_proc_busy, clk, rst, 1'b1, (proc & ~busy) == '0, "processing group is free for insert")
  `GRFB_ASSERT_NEXT(a_release, clk, rst, cmd.decide && rel_group, !queued[$past(hg)], "released group still queued")

endmodule

// ===== rtl/core/gop_reverse_frame_buffer_core.sv =====
// Top level of the reverse-playback frame buffer: controller, datapath and channels.
//
//  Channel | Direction | Word contents
//  --------+-----------+------------------------------------------
//  req     | in        | req_type, frame_handle, is_key_frame
//  rsp     | out       | status, out_handle
//
// Each word passes a decide step, which picks the group, updates the group state and
// accesses the frame store, then a finish step, which registers the result in the
// output register. A new word is taken in the cycle the previous result is registered,
// so while rsp drains the core takes a new word without first returning to idle.
// While the output register holds an untaken result, a word that reaches its last step waits
// there, taking no further word. Reset clears all group and queue state, not the frame store.
module gop_reverse_frame_buffer_core #(
  parameter int GROUPS           = 4,
  parameter int FRAMES_PER_GROUP = 64,
  parameter int HANDLE_BITS      = 32
) (
  input logic         clk,
  input logic         rst,
  grfb_req_if.sink    req,
  grfb_rsp_if.source  rsp
);
  import grfb_pkg::*;

  grfb_cmd_t  cmd;
  grfb_stat_t stat;

  grfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  grfb_dp #(
    .GROUPS           (GROUPS),
    .FRAMES_PER_GROUP (FRAMES_PER_GROUP),
    .HANDLE_BITS      (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .frame_handle (req.frame_handle),
    .is_key_frame (req.is_key_frame),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (rsp.status),
    .out_handle   (rsp.out_handle)
  );

endmodule
